FILE: rtl/core/pib_pkg.sv
// Shared types, constants and fixed-point helpers for the particle integrate unit.
package pib_pkg;

   localparam int Q_W     = 32;
   localparam int DT_W    = 17;
   localparam int LIM_W   = 31;
   localparam int SQ_W    = 64;
   localparam int ROOT_W  = 32;
   localparam int NUM_W   = 62;
   localparam int CSR_IDX_W = 3;
   localparam int SQRT_STAGES = ROOT_W;
   localparam int DIV_STAGES  = LIM_W;
   localparam int SIDE_DEPTH  = SQRT_STAGES + DIV_STAGES + 1;
   localparam logic [16:0] DAMP_Q16 = 17'd59638;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIME_STEP   = 3'd0,
      CSR_SPEED_LIMIT = 3'd1,
      CSR_BOX_X_LOW   = 3'd2,
      CSR_BOX_X_HIGH  = 3'd3,
      CSR_BOX_Y_LOW   = 3'd4,
      CSR_BOX_Y_HIGH  = 3'd5,
      CSR_BOX_Z_LOW   = 3'd6,
      CSR_BOX_Z_HIGH  = 3'd7
   } csr_idx_type;

   typedef logic signed [Q_W-1:0] q_type;

   typedef struct packed {
      logic                     vld;
      logic                     clamp;
      q_type [2:0]              pos;
      q_type [2:0]              vel;
      logic [2:0]               neg;
      logic [2:0][NUM_W-1:0]    mlim;
   } side_type;

   function automatic q_type sat32(input logic signed [63:0] v);
      q_type r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [63:0] rnd16(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p + 64'sd32768;
      return s >>> 16;
   endfunction

endpackage

FILE: rtl/core/particle_integrate_and_bound_unit.sv
// Top level of the particle integrate, speed clamp and box reflection pipeline.
//
//   Channel | Direction | Transfer when          | Payload
//   req     | in        | req_tvalid & tready    | pos, vel, acc (x, y, z each)
//   rsp     | out       | rsp_tvalid & tready    | pos, vel (x, y, z each)
//   csr     | in        | csr_we                 | csr_index, csr_wdata
//
// One particle is taken every cycle while the output is not stalled, and its
// result passes through 72 register stages before it is valid at the output.
// Most of these stages are the 32-stage square root and 31-stage divider.
// Reset clears all valid bits and reloads the CSR registers to their defaults.
// When the output register holds a result that is not taken, the whole
// pipeline and the input stall together, so nothing is lost or repeated.
module particle_integrate_and_bound_unit
   import pib_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z
   input  logic [287:0]   req_tdata,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
   output logic [191:0]   rsp_tdata,
   input  logic           csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [Q_W-1:0] csr_wdata
);

   logic [DT_W-1:0]  dt_ff;
   logic [LIM_W-1:0] lim_ff;
   q_type [2:0]      lo_ff;
   q_type [2:0]      hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff  <= 17'd1049;
         lim_ff <= 31'd4915200;
         lo_ff  <= {32'sd0, 32'sd0, 32'sd0};
         hi_ff  <= {32'sd144179, 32'sd262144, 32'sd144179};
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_TIME_STEP:   dt_ff    <= csr_wdata[DT_W-1:0];
            CSR_SPEED_LIMIT: lim_ff   <= csr_wdata[LIM_W-1:0];
            CSR_BOX_X_LOW:   lo_ff[0] <= csr_wdata;
            CSR_BOX_X_HIGH:  hi_ff[0] <= csr_wdata;
            CSR_BOX_Y_LOW:   lo_ff[1] <= csr_wdata;
            CSR_BOX_Y_HIGH:  hi_ff[1] <= csr_wdata;
            CSR_BOX_Z_LOW:   lo_ff[2] <= csr_wdata;
            CSR_BOX_Z_HIGH:  hi_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic en;
   logic rsp_vld_ff;
   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = rsp_vld_ff;

   function automatic logic [Q_W-1:0] mag(input q_type v);
      return v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
   endfunction

   logic vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   q_type [2:0] pos1_ff, vel1_ff, pos2_ff, vel2_ff, pos3_ff, vel3_ff, pos4_ff, vel4_ff;
   logic signed [49:0] prod1_ff [3];
   logic [2:0] neg3_ff, neg4_ff;
   logic [SQ_W-1:0] sq3_ff [3];
   logic [2:0][NUM_W-1:0] mlim3_ff, mlim4_ff;
   logic [NUM_W-1:0] lim2_3_ff, lim2_4_ff;
   logic [SQ_W-1:0] s2_4_ff, s2_5_ff;
   side_type side_ff [SIDE_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= req_tvalid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            pos1_ff[i]  <= req_tdata[i*Q_W +: Q_W];
            vel1_ff[i]  <= req_tdata[(i+3)*Q_W +: Q_W];
            prod1_ff[i] <= $signed(req_tdata[(i+6)*Q_W +: Q_W]) * $signed({1'b0, dt_ff});
            vel2_ff[i]  <= sat32(64'(vel1_ff[i]) + rnd16(64'(prod1_ff[i])));
            neg3_ff[i]  <= vel2_ff[i][Q_W-1];
            sq3_ff[i]   <= 64'(mag(vel2_ff[i])) * 64'(mag(vel2_ff[i]));
            mlim3_ff[i] <= NUM_W'(mag(vel2_ff[i])) * NUM_W'(lim_ff);
         end
         pos2_ff   <= pos1_ff;
         pos3_ff   <= pos2_ff;
         vel3_ff   <= vel2_ff;
         lim2_3_ff <= NUM_W'(lim_ff) * NUM_W'(lim_ff);
         pos4_ff   <= pos3_ff;
         vel4_ff   <= vel3_ff;
         neg4_ff   <= neg3_ff;
         mlim4_ff  <= mlim3_ff;
         lim2_4_ff <= lim2_3_ff;
         s2_4_ff   <= sq3_ff[0] + sq3_ff[1] + sq3_ff[2];
         s2_5_ff   <= s2_4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0].clamp <= s2_4_ff > {2'b00, lim2_4_ff};
         side_ff[0].pos   <= pos4_ff;
         side_ff[0].vel   <= vel4_ff;
         side_ff[0].neg   <= neg4_ff;
         side_ff[0].mlim  <= mlim4_ff;
         for (int k = 1; k < SIDE_DEPTH; k++) begin
            side_ff[k].clamp <= side_ff[k-1].clamp;
            side_ff[k].pos   <= side_ff[k-1].pos;
            side_ff[k].vel   <= side_ff[k-1].vel;
            side_ff[k].neg   <= side_ff[k-1].neg;
            side_ff[k].mlim  <= side_ff[k-1].mlim;
         end
      end
      if (reset) begin
         for (int k = 0; k < SIDE_DEPTH; k++) begin
            side_ff[k].vld <= 1'b0;
         end
      end else if (en) begin
         side_ff[0].vld <= vld4_ff;
         for (int k = 1; k < SIDE_DEPTH; k++) begin
            side_ff[k].vld <= side_ff[k-1].vld;
         end
      end
   end

   logic [ROOT_W-1:0] len;
   logic [LIM_W-1:0]  quo [3];

   pib_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .x     (s2_5_ff),
      .root  (len)
   );

   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : g_div
         pib_div u_div (
            .clock (clock),
            .en    (en),
            .num   (side_ff[SQRT_STAGES].mlim[g]),
            .den   (len),
            .quo   (quo[g])
         );
      end
   endgenerate

   localparam int LAST = SIDE_DEPTH - 1;

   logic vlda_ff, vldb_ff, vldc_ff;
   q_type [2:0] posa_ff, vela_ff, posb_ff, velb_ff, npc_ff, velc_ff;
   logic signed [49:0] prodb_ff [3];
   logic signed [49:0] dampc_ff [3];
   q_type [2:0] rsp_pos_ff, rsp_vel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vlda_ff    <= 1'b0;
         vldb_ff    <= 1'b0;
         vldc_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         vlda_ff    <= side_ff[LAST].vld;
         vldb_ff    <= vlda_ff;
         vldc_ff    <= vldb_ff;
         rsp_vld_ff <= vldc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         posa_ff <= side_ff[LAST].pos;
         posb_ff <= posa_ff;
         velb_ff <= vela_ff;
         velc_ff <= velb_ff;
         for (int i = 0; i < 3; i++) begin
            if (side_ff[LAST].clamp) begin
               vela_ff[i] <= side_ff[LAST].neg[i] ? -$signed({1'b0, quo[i]})
                                                  : $signed({1'b0, quo[i]});
            end else begin
               vela_ff[i] <= side_ff[LAST].vel[i];
            end
            prodb_ff[i] <= $signed(vela_ff[i]) * $signed({1'b0, dt_ff});
            npc_ff[i]   <= sat32(64'(posb_ff[i]) + rnd16(64'(prodb_ff[i])));
            dampc_ff[i] <= -$signed({velb_ff[i][Q_W-1], velb_ff[i]}) * $signed(DAMP_Q16);
            if (npc_ff[i] < lo_ff[i]) begin
               rsp_pos_ff[i] <= sat32(64'(lo_ff[i]) + 64'sd1);
               rsp_vel_ff[i] <= sat32(rnd16(64'(dampc_ff[i])));
            end else if (npc_ff[i] > hi_ff[i]) begin
               rsp_pos_ff[i] <= sat32(64'(hi_ff[i]) - 64'sd1);
               rsp_vel_ff[i] <= sat32(rnd16(64'(dampc_ff[i])));
            end else begin
               rsp_pos_ff[i] <= npc_ff[i];
               rsp_vel_ff[i] <= velc_ff[i];
            end
         end
      end
   end

   assign rsp_tdata = {rsp_vel_ff[2], rsp_vel_ff[1], rsp_vel_ff[0],
                       rsp_pos_ff[2], rsp_pos_ff[1], rsp_pos_ff[0]};

endmodule

FILE: rtl/core/pib_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
module pib_isqrt
   import pib_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [SQ_W-1:0]   x,
   output logic [ROOT_W-1:0] root
);

   logic [SQ_W-1:0]   x_ff    [SQRT_STAGES];
   logic [ROOT_W:0]   rem_ff  [SQRT_STAGES];
   logic [ROOT_W-1:0] root_ff [SQRT_STAGES];

   genvar k;
   generate
      for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
         logic [SQ_W-1:0]   x_prev;
         logic [ROOT_W:0]   rem_prev;
         logic [ROOT_W-1:0] root_prev;
         logic [ROOT_W+2:0] r2;
         logic [ROOT_W+2:0] t;
         logic [ROOT_W+2:0] d;
         if (k == 0) begin : g_first
            assign x_prev    = x;
            assign rem_prev  = '0;
            assign root_prev = '0;
         end else begin : g_next
            assign x_prev    = x_ff[k-1];
            assign rem_prev  = rem_ff[k-1];
            assign root_prev = root_ff[k-1];
         end
         assign r2 = {rem_prev, x_prev[SQ_W-1 -: 2]};
         assign t  = {1'b0, root_prev, 2'b01};
         assign d  = r2 - t;
         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[k] <= {x_prev[SQ_W-3:0], 2'b00};
               if (r2 >= t) begin
                  rem_ff[k]  <= d[ROOT_W:0];
                  root_ff[k] <= {root_prev[ROOT_W-2:0], 1'b1};
               end else begin
                  rem_ff[k]  <= r2[ROOT_W:0];
                  root_ff[k] <= {root_prev[ROOT_W-2:0], 1'b0};
               end
            end
         end
      end
   endgenerate

   assign root = root_ff[SQRT_STAGES-1];

endmodule

FILE: rtl/core/pib_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module pib_div
   import pib_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [NUM_W-1:0]  num,
   input  logic [ROOT_W-1:0] den,
   output logic [LIM_W-1:0]  quo
);

   logic [LIM_W-1:0]  low_ff [DIV_STAGES];
   logic [ROOT_W-1:0] rem_ff [DIV_STAGES];
   logic [ROOT_W-1:0] den_ff [DIV_STAGES];
   logic [LIM_W-1:0]  quo_ff [DIV_STAGES];

   genvar k;
   generate
      for (k = 0; k < DIV_STAGES; k++) begin : g_stage
         logic [LIM_W-1:0]  low_prev;
         logic [ROOT_W-1:0] rem_prev;
         logic [ROOT_W-1:0] den_prev;
         logic [LIM_W-1:0]  quo_prev;
         logic [ROOT_W:0]   r2;
         logic [ROOT_W:0]   d;
         if (k == 0) begin : g_first
            assign low_prev = num[LIM_W-1:0];
            assign rem_prev = {1'b0, num[NUM_W-1:LIM_W]};
            assign den_prev = den;
            assign quo_prev = '0;
         end else begin : g_next
            assign low_prev = low_ff[k-1];
            assign rem_prev = rem_ff[k-1];
            assign den_prev = den_ff[k-1];
            assign quo_prev = quo_ff[k-1];
         end
         assign r2 = {rem_prev, low_prev[LIM_W-1]};
         assign d  = r2 - {1'b0, den_prev};
         always_ff @(posedge clock) begin
            if (en) begin
               low_ff[k] <= {low_prev[LIM_W-2:0], 1'b0};
               den_ff[k] <= den_prev;
               if (r2 >= {1'b0, den_prev}) begin
                  rem_ff[k] <= d[ROOT_W-1:0];
                  quo_ff[k] <= {quo_prev[LIM_W-2:0], 1'b1};
               end else begin
                  rem_ff[k] <= r2[ROOT_W-1:0];
                  quo_ff[k] <= {quo_prev[LIM_W-2:0], 1'b0};
               end
            end
         end
      end
   endgenerate

   assign quo = quo_ff[DIV_STAGES-1];

endmodule
